[rtl/rnc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnc_pkg
// Shared types, constants and arithmetic helpers of the RGB contrast map core.
// ----------------------------------------------------------------------------
package rnc_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 2048;
	localparam int unsigned MAX_HEIGHT_DEF = 4096;

	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned SAD_W      = 10;
	localparam int unsigned MEAN_W     = 8;
	localparam int unsigned PIX_ROW_W  = 12;
	localparam int unsigned PIX_COL_W  = 11;

	localparam int unsigned IN_TDATA_W  = 24;
	localparam int unsigned OUT_TDATA_W = 48;
	localparam int unsigned OUT_TUSER_W = 2;

	localparam int unsigned CFG_ADDR_W = 2;
	localparam int unsigned CFG_DATA_W = 13;
	localparam int unsigned THR_W      = 8;
	localparam int unsigned WIDTH_W    = 12;
	localparam int unsigned HEIGHT_W   = 13;

	localparam logic [THR_W-1:0] THR_RST = '0;
	localparam int unsigned CFG_WIDTH_RST  = 640;
	localparam int unsigned CFG_HEIGHT_RST = 480;

	// x/3 for x <= 765 as (x * 683) >> 11
	localparam int unsigned DIV3_MUL   = 683;
	localparam int unsigned DIV3_SHIFT = 11;
	localparam int unsigned PROD_W     = 20;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_WIDTH     = 2'd1,
		CFG_HEIGHT    = 2'd2
	} cfg_idx_t;

	// result kinds, emitted lowest first
	localparam int unsigned RES_INNER    = 0;  // upper-left pixel, all neighbors known
	localparam int unsigned RES_LAST_COL = 1;  // upper pixel in last column
	localparam int unsigned RES_LAST_ROW = 2;  // left pixel in last row
	localparam int unsigned RES_CORNER   = 3;  // bottom-right pixel
	localparam int unsigned RES_N        = 4;

	typedef logic [RES_N-1:0] res_mask_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		rgb_t                 cur;
		rgb_t                 left;
		rgb_t                 ul;
		logic [PIX_ROW_W-1:0] row;
		logic [PIX_COL_W-1:0] col;
		res_mask_t            mask;
	} s1_t;

	typedef struct packed {
		logic [SAD_W-1:0]     ul_up;
		logic [SAD_W-1:0]     ul_left;
		logic [SAD_W-1:0]     ul_cur;
		logic [SAD_W-1:0]     up_cur;
		logic [SAD_W-1:0]     left_cur;
		logic [PIX_ROW_W-1:0] row;
		logic [PIX_COL_W-1:0] col;
		res_mask_t            mask;
	} s2_t;

	typedef struct packed {
		logic [MEAN_W-1:0]    inner_right;
		logic [MEAN_W-1:0]    inner_down;
		logic [MEAN_W-1:0]    inner_diag;
		logic [MEAN_W-1:0]    col_down;
		logic [MEAN_W-1:0]    row_right;
		logic [PIX_ROW_W-1:0] row;
		logic [PIX_COL_W-1:0] col;
	} s3_t;

	typedef struct packed {
		logic [PIX_ROW_W-1:0] pixel_row;
		logic [PIX_COL_W-1:0] pixel_col;
		logic [MEAN_W-1:0]    right_contrast;
		logic [MEAN_W-1:0]    down_contrast;
		logic [MEAN_W-1:0]    diag_contrast;
		logic                 right_valid;
		logic                 down_valid;
		logic                 last_of_run;
	} result_t;

	function automatic int unsigned size_m1(int unsigned v, int unsigned vmax);
		int unsigned s;
		s = v;
		if (s < 2) s = 2;
		if (s > vmax) s = vmax;
		return s - 1;
	endfunction

	function automatic logic [CHAN_W-1:0] absdiff(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic logic [SAD_W-1:0] sad3(rgb_t p, rgb_t q);
		return SAD_W'(absdiff(p.red, q.red)) + SAD_W'(absdiff(p.green, q.green))
			+ SAD_W'(absdiff(p.blue, q.blue));
	endfunction

	function automatic logic [MEAN_W-1:0] mean3(logic [SAD_W-1:0] sad, logic [THR_W-1:0] thr);
		logic [PROD_W-1:0] prod;
		logic [MEAN_W-1:0] m;
		prod = PROD_W'(sad) * PROD_W'(DIV3_MUL);
		m = prod[DIV3_SHIFT +: MEAN_W];
		return (m < thr) ? '0 : m;
	endfunction

endpackage

[rtl/rnc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnc_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module rnc_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/rnc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnc_front
// Config registers, raster position, line store access and first stage.
// ----------------------------------------------------------------------------
module rnc_front #(
	parameter int unsigned MAX_WIDTH  = rnc_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = rnc_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rnc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [rnc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  rnc_pkg::rgb_t                  in_pixel,
	output logic                           s1_valid,
	output rnc_pkg::s1_t                   s1_item,
	output rnc_pkg::rgb_t                  s1_upper,
	input  logic                           s1_take,
	output logic [rnc_pkg::THR_W-1:0]      threshold
);
	import rnc_pkg::*;

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned RW = $clog2(MAX_HEIGHT);

	logic [THR_W-1:0] thr_q;
	logic [CW-1:0]    wm1_q;
	logic [RW-1:0]    hm1_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	rgb_t             left_q;
	logic             first_q;
	logic             s1_v_q;
	s1_t              s1_q;
	rgb_t             rd_data;
	cfg_idx_t         cfg_idx;
	logic             restart;
	logic             accept;
	logic             last_col;
	logic             last_row;
	res_mask_t        mask;

	assign cfg_ready = 1'b1;
	assign cfg_idx   = cfg_idx_t'(cfg_addr);
	assign in_ready  = !s1_v_q || s1_take;
	assign accept    = in_valid && in_ready;
	assign last_col  = (col_q == wm1_q);
	assign last_row  = (row_q == hm1_q);

	always_comb begin
		case (cfg_idx)
			CFG_WIDTH, CFG_HEIGHT: restart = cfg_valid;
			default: restart = 1'b0;
		endcase
	end

	always_comb begin
		mask               = '0;
		mask[RES_INNER]    = (row_q != '0) && (col_q != '0);
		mask[RES_LAST_COL] = (row_q != '0) && last_col;
		mask[RES_LAST_ROW] = last_row && (col_q != '0);
		mask[RES_CORNER]   = last_row && last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RST;
			wm1_q <= CW'(size_m1(CFG_WIDTH_RST, MAX_WIDTH));
			hm1_q <= RW'(size_m1(CFG_HEIGHT_RST, MAX_HEIGHT));
		end else if (cfg_valid) begin
			case (cfg_idx)
				CFG_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
				CFG_WIDTH:     wm1_q <= CW'(size_m1(32'(cfg_data[WIDTH_W-1:0]), MAX_WIDTH));
				CFG_HEIGHT:    hm1_q <= RW'(size_m1(32'(cfg_data[HEIGHT_W-1:0]), MAX_HEIGHT));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			left_q  <= '0;
			first_q <= 1'b1;
		end else if (restart) begin
			col_q   <= '0;
			row_q   <= '0;
			left_q  <= '0;
			first_q <= 1'b1;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
			left_q  <= in_pixel;
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (accept) begin
			s1_v_q <= 1'b1;
		end else if (s1_take) begin
			s1_v_q <= 1'b0;
		end
	end

	// rd_data still holds the upper pixel of the previous item here
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q.cur  <= in_pixel;
			s1_q.left <= left_q;
			s1_q.ul   <= first_q ? '0 : rd_data;
			s1_q.row  <= PIX_ROW_W'(row_q);
			s1_q.col  <= PIX_COL_W'(col_q);
			s1_q.mask <= mask;
		end
	end

	rnc_ram #(
		.WIDTH ($bits(rgb_t)),
		.DEPTH (MAX_WIDTH)
	) u_row_store (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (in_pixel),
		.re    (accept),
		.raddr (col_q),
		.rdata (rd_data)
	);

	assign s1_valid  = s1_v_q;
	assign s1_item   = s1_q;
	assign s1_upper  = rd_data;
	assign threshold = thr_q;

endmodule

[rtl/rnc_sad.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnc_sad
// Second stage: channel absolute-difference sums for the five pixel pairs.
// ----------------------------------------------------------------------------
module rnc_sad (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s1_valid,
	input  rnc_pkg::s1_t  s1_item,
	input  rnc_pkg::rgb_t s1_upper,
	output logic          s1_take,
	output logic          s2_valid,
	output rnc_pkg::s2_t  s2_item,
	input  logic          s2_take
);
	import rnc_pkg::*;

	logic s2_v_q;
	s2_t  s2_q;

	assign s1_take = s1_valid && (!s2_v_q || s2_take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q <= 1'b0;
		end else if (s1_take) begin
			s2_v_q <= 1'b1;
		end else if (s2_take) begin
			s2_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			s2_q.ul_up    <= sad3(s1_item.ul, s1_upper);
			s2_q.ul_left  <= sad3(s1_item.ul, s1_item.left);
			s2_q.ul_cur   <= sad3(s1_item.ul, s1_item.cur);
			s2_q.up_cur   <= sad3(s1_upper, s1_item.cur);
			s2_q.left_cur <= sad3(s1_item.left, s1_item.cur);
			s2_q.row      <= s1_item.row;
			s2_q.col      <= s1_item.col;
			s2_q.mask     <= s1_item.mask;
		end
	end

	assign s2_valid = s2_v_q;
	assign s2_item  = s2_q;

endmodule

[rtl/rnc_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnc_emit
// Mean, threshold and diagonal max; serializes up to four results per item
// into the output register.
// ----------------------------------------------------------------------------
module rnc_emit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [rnc_pkg::THR_W-1:0] threshold,
	input  logic                      s2_valid,
	input  rnc_pkg::s2_t              s2_item,
	output logic                      s2_take,
	output logic                      res_valid,
	output rnc_pkg::result_t          res,
	input  logic                      res_ready
);
	import rnc_pkg::*;

	logic      s3_v_q;
	res_mask_t mask_q;
	s3_t       s3_q;
	s3_t       s3_d;
	logic      ov_q;
	result_t   out_q;
	result_t   nxt;
	res_mask_t sel;
	res_mask_t rem;
	logic      out_free;
	logic      emit;
	logic      s3_free;
	logic [MEAN_W-1:0] diag_raw;

	always_comb begin
		s3_d.inner_right = mean3(s2_item.ul_up, threshold);
		s3_d.inner_down  = mean3(s2_item.ul_left, threshold);
		diag_raw         = mean3(s2_item.ul_cur, threshold);
		s3_d.inner_diag  = diag_raw;
		if (s3_d.inner_diag < s3_d.inner_right) s3_d.inner_diag = s3_d.inner_right;
		if (s3_d.inner_diag < s3_d.inner_down) s3_d.inner_diag = s3_d.inner_down;
		s3_d.col_down    = mean3(s2_item.up_cur, threshold);
		s3_d.row_right   = mean3(s2_item.left_cur, threshold);
		s3_d.row         = s2_item.row;
		s3_d.col         = s2_item.col;
	end

	assign out_free = !ov_q || res_ready;
	assign sel      = mask_q & (~mask_q + res_mask_t'(1));
	assign rem      = mask_q & ~sel;
	assign emit     = s3_v_q && (mask_q != '0) && out_free;
	assign s3_free  = !s3_v_q || (mask_q == '0) || (emit && (rem == '0));
	assign s2_take  = s2_valid && s3_free;

	always_comb begin
		nxt                = '0;
		nxt.pixel_row      = s3_q.row;
		nxt.pixel_col      = s3_q.col;
		nxt.last_of_run    = (rem == '0);
		if (sel[RES_INNER]) begin
			nxt.pixel_row      = s3_q.row - PIX_ROW_W'(1);
			nxt.pixel_col      = s3_q.col - PIX_COL_W'(1);
			nxt.right_contrast = s3_q.inner_right;
			nxt.down_contrast  = s3_q.inner_down;
			nxt.diag_contrast  = s3_q.inner_diag;
			nxt.right_valid    = 1'b1;
			nxt.down_valid     = 1'b1;
		end else if (sel[RES_LAST_COL]) begin
			nxt.pixel_row      = s3_q.row - PIX_ROW_W'(1);
			nxt.down_contrast  = s3_q.col_down;
			nxt.down_valid     = 1'b1;
		end else if (sel[RES_LAST_ROW]) begin
			nxt.pixel_col      = s3_q.col - PIX_COL_W'(1);
			nxt.right_contrast = s3_q.row_right;
			nxt.right_valid    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v_q <= 1'b0;
			mask_q <= '0;
		end else if (s2_take) begin
			s3_v_q <= 1'b1;
			mask_q <= s2_item.mask;
		end else if (s3_free) begin
			s3_v_q <= 1'b0;
			mask_q <= '0;
		end else if (emit) begin
			mask_q <= rem;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_take) begin
			s3_q <= s3_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit) begin
			ov_q <= 1'b1;
		end else if (res_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= nxt;
		end
	end

	assign res_valid = ov_q;
	assign res       = out_q;

endmodule

[rtl/rgb_neighbour_contrast_map_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_neighbour_contrast_map_core
// Streaming RGB contrast map against right, lower and lower-right neighbors.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one item per cycle unless the input is held;
// the previous row sits in a one-port-read, one-port-write line store that is
// read and written at the pixel's column in the cycle the pixel is taken. A
// result passes the input register with the line store read, the difference
// sums, the mean and threshold, and the output register. Inside the image one
// pixel gives one result and the core runs at one pixel per cycle unless the
// output is stalled; the last column and the last row give two results per
// pixel and the bottom-right pixel four, and since the single output port
// moves one result per cycle, each extra result holds the input back. Writing
// image_width or image_height restarts the image at row 0, column 0 while the
// line store keeps its contents; the store has no clearing pass, so after a
// width change only columns written earlier hold defined data.
// ----------------------------------------------------------------------------
module rgb_neighbour_contrast_map_core #(
	parameter int unsigned MAX_WIDTH  = rnc_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = rnc_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [rnc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // blue, green, red
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// pixel_row, pixel_col, right_contrast, down_contrast, diag_contrast, pad
	output logic [rnc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [rnc_pkg::OUT_TUSER_W-1:0] m_axis_tuser,  // right_valid, down_valid
	output logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rnc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [rnc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rnc_pkg::*;

	rgb_t             in_pixel;
	logic             s1_valid;
	s1_t              s1_item;
	rgb_t             s1_upper;
	logic             s1_take;
	logic             s2_valid;
	s2_t              s2_item;
	logic             s2_take;
	logic [THR_W-1:0] threshold;
	result_t          res;

	assign in_pixel.blue  = s_axis_tdata[CHAN_W-1:0];
	assign in_pixel.green = s_axis_tdata[2*CHAN_W-1:CHAN_W];
	assign in_pixel.red   = s_axis_tdata[3*CHAN_W-1:2*CHAN_W];

	rnc_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_pixel  (in_pixel),
		.s1_valid  (s1_valid),
		.s1_item   (s1_item),
		.s1_upper  (s1_upper),
		.s1_take   (s1_take),
		.threshold (threshold)
	);

	rnc_sad u_sad (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.s1_item  (s1_item),
		.s1_upper (s1_upper),
		.s1_take  (s1_take),
		.s2_valid (s2_valid),
		.s2_item  (s2_item),
		.s2_take  (s2_take)
	);

	rnc_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.threshold (threshold),
		.s2_valid  (s2_valid),
		.s2_item   (s2_item),
		.s2_take   (s2_take),
		.res_valid (m_axis_tvalid),
		.res       (res),
		.res_ready (m_axis_tready)
	);

	assign m_axis_tdata = {1'b0, res.diag_contrast, res.down_contrast, res.right_contrast,
		res.pixel_col, res.pixel_row};
	assign m_axis_tuser = {res.down_valid, res.right_valid};
	assign m_axis_tlast = res.last_of_run;

	a_right_missing: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !res.right_valid |-> res.right_contrast == '0)
		else $error("right contrast without right neighbor");

	a_diag_needs_both: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !(res.right_valid && res.down_valid) |-> res.diag_contrast == '0)
		else $error("diagonal contrast without both neighbors");

	a_diag_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.right_valid && res.down_valid |->
			res.diag_contrast >= res.right_contrast && res.diag_contrast >= res.down_contrast)
		else $error("diagonal contrast below right or down");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> s1_valid && !s1_take)
		else $error("input stalled with first stage free");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB neighbor contrast map core.
// ----------------------------------------------------------------------------
// Pixels are streamed into the core as whole images, and sometimes as broken
// images cut short by a size write. A behavioral contrast model in the bench
// tracks the line buffer, the position and the registers. For every pixel the
// core accepts, it queues the results that the pixel completes. Each result
// leaving the core is checked field by field, in order, against that queue.
// The bench starts with a short table of directed images, corner sizes and
// threshold edges. A random run over many small image shapes follows. Then
// comes one small image with no idling on either side, and last a few pixels
// at clamped sizes. Both stream sides idle at random. The output side holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
	import rnc_pkg::*;

	localparam realtime     CLK_HALF      = 4.0;
	localparam int unsigned RST_CYCLES    = 4;
	localparam int unsigned DRAIN_CYCLES  = 12;
	localparam int unsigned END_WAIT      = 5000;
	localparam int unsigned LIMIT_CYCLES  = 600000;
	localparam int unsigned LONG_STALL    = 300;
	localparam int unsigned RANDOM_PIXELS = 300;
	localparam int unsigned STEADY_W      = 10;
	localparam int unsigned STEADY_H      = 8;
	localparam int unsigned CLAMP_PIXELS  = 25;

	localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

	// output tdata layout
	localparam int unsigned ROW_LSB   = 0;
	localparam int unsigned COL_LSB   = ROW_LSB + PIX_ROW_W;
	localparam int unsigned RIGHT_LSB = COL_LSB + PIX_COL_W;
	localparam int unsigned DOWN_LSB  = RIGHT_LSB + MEAN_W;
	localparam int unsigned DIAG_LSB  = DOWN_LSB + MEAN_W;
	localparam int unsigned PAD_LSB   = DIAG_LSB + MEAN_W;

	typedef enum logic {STEP_REG, STEP_PIX} step_kind_t;

	typedef struct {
		step_kind_t            kind;
		logic [CFG_ADDR_W-1:0] addr;
		logic [CFG_DATA_W-1:0] data;
		rgb_t                  pix;
		bit                    typed;
		result_t               want;
	} step_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;
	logic                   m_axis_tlast;
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic [CFG_ADDR_W-1:0]  cfg_addr      = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;

	// contrast model state
	rgb_t                line_mem [MAX_WIDTH_DEF];
	rgb_t                left_px;
	rgb_t                upleft_px;
	int unsigned         col_pos;
	int unsigned         row_pos;
	logic [THR_W-1:0]    thr_reg;
	logic [WIDTH_W-1:0]  width_reg;
	logic [HEIGHT_W-1:0] height_reg;
	result_t             fresh [RES_N];
	int unsigned         fresh_n;

	result_t     contrast_q [$];
	step_t       steps [$];
	int unsigned mismatches = 0;
	int unsigned cycle_cnt  = 0;
	int unsigned stall_asks = 0;
	int unsigned stall_seen = 0;
	int unsigned stall_left = 0;
	bit          steady     = 1'b0;

	rgb_neighbour_contrast_map_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("FAIL rgb_neighbour_contrast_map_core");
			$finish;
		end
	end

	function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
		if (v < 2) return 2;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic [MEAN_W-1:0] mean_gap(rgb_t a, rgb_t b);
		int s;
		int d;
		s = 0;
		for (int k = 0; k < 3; k++) begin
			d = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
			s += (d < 0) ? -d : d;
		end
		s = s / 3;
		return (s < int'(thr_reg)) ? '0 : MEAN_W'(s);
	endfunction

	function automatic result_t make_result(int unsigned r, int unsigned c, rgb_t orig,
		bit has_r, rgb_t rp, bit has_d, rgb_t dp, rgb_t gp);
		result_t res;
		logic [MEAN_W-1:0] g;
		res.pixel_row      = PIX_ROW_W'(r);
		res.pixel_col      = PIX_COL_W'(c);
		res.right_contrast = has_r ? mean_gap(orig, rp) : '0;
		res.down_contrast  = has_d ? mean_gap(orig, dp) : '0;
		g = '0;
		if (has_r && has_d) begin
			g = mean_gap(orig, gp);
			if (g < res.right_contrast) g = res.right_contrast;
			if (g < res.down_contrast) g = res.down_contrast;
		end
		res.diag_contrast = g;
		res.right_valid   = has_r;
		res.down_valid    = has_d;
		res.last_of_run   = 1'b0;
		return res;
	endfunction

	function automatic void restart_image();
		left_px   = '0;
		upleft_px = '0;
		col_pos   = 0;
		row_pos   = 0;
	endfunction

	function automatic void apply_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_THRESHOLD: thr_reg = val[THR_W-1:0];
			CFG_WIDTH: begin
				width_reg = val[WIDTH_W-1:0];
				restart_image();
			end
			CFG_HEIGHT: begin
				height_reg = val[HEIGHT_W-1:0];
				restart_image();
			end
			default: ;
		endcase
	endfunction

	// fills fresh[] with the results this pixel completes, in output order
	function automatic void predict_pixel(rgb_t cur);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		rgb_t above;
		bit end_col;
		bit end_row;
		w = clamp_size(32'(width_reg), MAX_WIDTH_DEF);
		h = clamp_size(32'(height_reg), MAX_HEIGHT_DEF);
		c = (col_pos >= w) ? w - 1 : col_pos;
		r = (row_pos >= h) ? h - 1 : row_pos;
		end_col = (c == w - 1);
		end_row = (r == h - 1);
		above = line_mem[c];
		fresh_n = 0;
		if (r >= 1 && c >= 1) begin
			fresh[fresh_n] = make_result(r - 1, c - 1, upleft_px, 1'b1, above,
				1'b1, left_px, cur);
			fresh_n++;
		end
		if (r >= 1 && end_col) begin
			fresh[fresh_n] = make_result(r - 1, c, above, 1'b0, '0, 1'b1, cur, '0);
			fresh_n++;
		end
		if (end_row && c >= 1) begin
			fresh[fresh_n] = make_result(r, c - 1, left_px, 1'b1, cur, 1'b0, '0, '0);
			fresh_n++;
		end
		if (end_row && end_col) begin
			fresh[fresh_n] = make_result(r, c, cur, 1'b0, '0, 1'b0, '0, '0);
			fresh_n++;
		end
		if (fresh_n > 0)
			fresh[fresh_n - 1].last_of_run = 1'b1;
		line_mem[c] = cur;
		upleft_px   = above;
		left_px     = cur;
		if (end_col) begin
			col_pos = 0;
			row_pos = end_row ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endfunction

	function automatic result_t known_result(int unsigned r, int unsigned c,
		int unsigned rc, int unsigned dc, int unsigned gc, bit rv, bit dv, bit lst);
		result_t res;
		res.pixel_row      = PIX_ROW_W'(r);
		res.pixel_col      = PIX_COL_W'(c);
		res.right_contrast = MEAN_W'(rc);
		res.down_contrast  = MEAN_W'(dc);
		res.diag_contrast  = MEAN_W'(gc);
		res.right_valid    = rv;
		res.down_valid     = dv;
		res.last_of_run    = lst;
		return res;
	endfunction

	function automatic step_t reg_step(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		step_t s;
		s.kind  = STEP_REG;
		s.addr  = idx;
		s.data  = val;
		s.pix   = '0;
		s.typed = 1'b0;
		s.want  = '0;
		return s;
	endfunction

	function automatic step_t pix_step(rgb_t px, bit typed, result_t want);
		step_t s;
		s.kind  = STEP_PIX;
		s.addr  = '0;
		s.data  = '0;
		s.pix   = px;
		s.typed = typed;
		s.want  = want;
		return s;
	endfunction

	function automatic void add_step(step_t s);
		steps = {steps, s};
	endfunction

	function automatic rgb_t random_pixel();
		rgb_t p;
		logic [7:0] base;
		base = 8'($urandom_range(255));
		case ($urandom_range(3))
			0: begin
				p.red   = base ^ 8'($urandom_range(7));
				p.green = base ^ 8'($urandom_range(7));
				p.blue  = base ^ 8'($urandom_range(7));
			end
			1: begin
				p.red   = {8{1'($urandom_range(1))}};
				p.green = {8{1'($urandom_range(1))}};
				p.blue  = {8{1'($urandom_range(1))}};
			end
			default: p = 24'($urandom);
		endcase
		return p;
	endfunction

	task automatic report_mismatch(input string what, input logic [OUT_TDATA_W-1:0] got,
		input logic [OUT_TDATA_W-1:0] want);
		mismatches++;
		$display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	task automatic check_result();
		result_t want;
		if (contrast_q.size() == 0) begin
			report_mismatch("result with none expected", m_axis_tdata, '0);
			return;
		end
		want = contrast_q.pop_front();
		if (m_axis_tdata[ROW_LSB +: PIX_ROW_W] !== want.pixel_row)
			report_mismatch("pixel_row", OUT_TDATA_W'(m_axis_tdata[ROW_LSB +: PIX_ROW_W]),
				OUT_TDATA_W'(want.pixel_row));
		if (m_axis_tdata[COL_LSB +: PIX_COL_W] !== want.pixel_col)
			report_mismatch("pixel_col", OUT_TDATA_W'(m_axis_tdata[COL_LSB +: PIX_COL_W]),
				OUT_TDATA_W'(want.pixel_col));
		if (m_axis_tdata[RIGHT_LSB +: MEAN_W] !== want.right_contrast)
			report_mismatch("right_contrast", OUT_TDATA_W'(m_axis_tdata[RIGHT_LSB +: MEAN_W]),
				OUT_TDATA_W'(want.right_contrast));
		if (m_axis_tdata[DOWN_LSB +: MEAN_W] !== want.down_contrast)
			report_mismatch("down_contrast", OUT_TDATA_W'(m_axis_tdata[DOWN_LSB +: MEAN_W]),
				OUT_TDATA_W'(want.down_contrast));
		if (m_axis_tdata[DIAG_LSB +: MEAN_W] !== want.diag_contrast)
			report_mismatch("diag_contrast", OUT_TDATA_W'(m_axis_tdata[DIAG_LSB +: MEAN_W]),
				OUT_TDATA_W'(want.diag_contrast));
		if (m_axis_tdata[PAD_LSB] !== 1'b0)
			report_mismatch("tdata pad", OUT_TDATA_W'(m_axis_tdata[PAD_LSB]), '0);
		if (m_axis_tuser[0] !== want.right_valid)
			report_mismatch("right_valid", OUT_TDATA_W'(m_axis_tuser[0]),
				OUT_TDATA_W'(want.right_valid));
		if (m_axis_tuser[1] !== want.down_valid)
			report_mismatch("down_valid", OUT_TDATA_W'(m_axis_tuser[1]),
				OUT_TDATA_W'(want.down_valid));
		if (m_axis_tlast !== want.last_of_run)
			report_mismatch("last_of_run", OUT_TDATA_W'(m_axis_tlast),
				OUT_TDATA_W'(want.last_of_run));
	endtask

	// result sink: random backpressure, plus a long hold-off on request
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
			check_result();
		if (stall_asks != stall_seen) begin
			stall_seen = stall_asks;
			stall_left = LONG_STALL;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= steady || ($urandom_range(99) >= 8);
		end
	end

	// valid stays high after an item so back-to-back pixels need one assignment per step
	task automatic put_pixel(input rgb_t px, input bit typed, input result_t want);
		while (!steady && $urandom_range(99) < 8) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_pixel(px);
		if (typed && fresh_n > 0)
			fresh[0] = want;
		for (int k = 0; k < fresh_n; k++)
			contrast_q = {contrast_q, fresh[k]};
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (contrast_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_addr  <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		apply_reg(idx, val);
	endtask

	initial begin
		int unsigned n_rand;
		int unsigned phase;
		int unsigned area;
		int unsigned count;
		int unsigned waited;
		logic [THR_W-1:0] thr;
		logic [CFG_DATA_W-1:0] val;

		foreach (line_mem[i]) line_mem[i] = '0;
		restart_image();
		thr_reg    = THR_RST;
		width_reg  = WIDTH_W'(CFG_WIDTH_RST);
		height_reg = HEIGHT_W'(CFG_HEIGHT_RST);

		// pixels are {red, green, blue}
		add_step(reg_step(CFG_THRESHOLD, 13'd0));
		add_step(reg_step(CFG_WIDTH, 13'd2));
		add_step(reg_step(CFG_HEIGHT, 13'd2));
		add_step(reg_step(CFG_UNUSED, 13'h1abc));
		add_step(pix_step(24'h000000, 1'b0, '0));
		add_step(pix_step(24'hffffff, 1'b0, '0));
		add_step(pix_step(24'hffffff, 1'b0, '0));
		add_step(pix_step(24'h000000, 1'b1,
			known_result(0, 0, 255, 255, 255, 1'b1, 1'b1, 1'b0)));
		// full-scale threshold: only the largest mean survives
		add_step(reg_step(CFG_THRESHOLD, 13'd255));
		add_step(pix_step(24'hffffff, 1'b0, '0));
		add_step(pix_step(24'h000000, 1'b0, '0));
		add_step(pix_step(24'hfefefe, 1'b0, '0));
		add_step(pix_step(24'h000000, 1'b1,
			known_result(0, 0, 255, 0, 255, 1'b1, 1'b1, 1'b0)));
		// sizes below range clamp to 2; a mean equal to the threshold is kept
		add_step(reg_step(CFG_THRESHOLD, 13'd85));
		add_step(reg_step(CFG_WIDTH, 13'd1));
		add_step(reg_step(CFG_HEIGHT, 13'd0));
		add_step(pix_step(24'h0000ff, 1'b0, '0));
		add_step(pix_step(24'h00ff00, 1'b0, '0));
		add_step(pix_step(24'hff0000, 1'b0, '0));
		add_step(pix_step(24'h000000, 1'b0, '0));
		// size write mid-image restarts, line buffer kept
		add_step(reg_step(CFG_THRESHOLD, 13'h1f00));
		add_step(reg_step(CFG_WIDTH, 13'd3));
		add_step(reg_step(CFG_HEIGHT, 13'd3));
		add_step(pix_step(24'h102030, 1'b0, '0));
		add_step(pix_step(24'h405060, 1'b0, '0));
		add_step(pix_step(24'h708090, 1'b0, '0));
		add_step(pix_step(24'ha0b0c0, 1'b0, '0));
		add_step(reg_step(CFG_HEIGHT, 13'd3));
		add_step(pix_step(24'h000000, 1'b0, '0));
		add_step(pix_step(24'hffffff, 1'b0, '0));
		add_step(pix_step(24'h123456, 1'b0, '0));
		add_step(pix_step(24'hffffff, 1'b0, '0));
		add_step(pix_step(24'h000000, 1'b0, '0));
		add_step(pix_step(24'h7f7f7f, 1'b0, '0));
		add_step(pix_step(24'h010203, 1'b0, '0));
		add_step(pix_step(24'hfefdfc, 1'b0, '0));
		add_step(pix_step(24'h800000, 1'b0, '0));

		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].kind == STEP_REG)
				write_reg(steps[i].addr, steps[i].data);
			else
				put_pixel(steps[i].pix, steps[i].typed, steps[i].want);
		end

		n_rand = 0;
		phase  = 0;
		while (n_rand < RANDOM_PIXELS) begin
			case ($urandom_range(3))
				0: thr = '0;
				1: thr = '1;
				default: thr = THR_W'($urandom_range(60));
			endcase
			write_reg(CFG_THRESHOLD, {5'($urandom), thr});
			if (phase == 0 || $urandom_range(2) != 0) begin
				val = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(1))
					: CFG_DATA_W'($urandom_range(2, 9));
				write_reg(CFG_WIDTH, val);
			end
			if (phase == 0 || $urandom_range(2) != 0) begin
				val = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(1))
					: CFG_DATA_W'($urandom_range(2, 6));
				write_reg(CFG_HEIGHT, val);
			end
			if (phase == 2)
				stall_asks <= stall_asks + 1;
			area = clamp_size(32'(width_reg), MAX_WIDTH_DEF)
				* clamp_size(32'(height_reg), MAX_HEIGHT_DEF);
			count = ($urandom_range(3) == 0) ? $urandom_range(1, area)
				: area * $urandom_range(1, 2);
			// two whole images under the long hold-off fill the core
			if (phase == 2)
				count = area * 2;
			if (count > RANDOM_PIXELS - n_rand)
				count = RANDOM_PIXELS - n_rand;
			for (int j = 0; j < count; j++) begin
				if (phase == 5 && j == count / 2)
					wait_idle();
				put_pixel(random_pixel(), 1'b0, '0);
			end
			n_rand += count;
			phase++;
		end

		// one whole image, no idling on either side
		steady <= 1'b1;
		write_reg(CFG_WIDTH, CFG_DATA_W'(STEADY_W));
		write_reg(CFG_HEIGHT, CFG_DATA_W'(STEADY_H));
		repeat (STEADY_W * STEADY_H) put_pixel(random_pixel(), 1'b0, '0);
		steady <= 1'b0;

		// sizes above range clamp to the maximum; a partial first row gives no results
		write_reg(CFG_THRESHOLD, 13'h1fff);
		write_reg(CFG_THRESHOLD, 13'd12);
		write_reg(CFG_WIDTH, 13'h1fff);
		write_reg(CFG_HEIGHT, 13'h1fff);
		repeat (CLAMP_PIXELS) put_pixel(random_pixel(), 1'b0, '0);

		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (contrast_q.size() != 0 && waited < END_WAIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (contrast_q.size() != 0)
			report_mismatch("results never sent", OUT_TDATA_W'(contrast_q.size()), '0);

		if (mismatches == 0)
			$display("PASS rgb_neighbour_contrast_map_core");
		else
			$display("FAIL rgb_neighbour_contrast_map_core");
		$finish;
	end

endmodule

[sim.f]
rtl/rnc_pkg.sv
rtl/rnc_ram.sv
rtl/rnc_front.sv
rtl/rnc_sad.sv
rtl/rnc_emit.sv
rtl/rgb_neighbour_contrast_map_core.sv
test/tb.sv
